@@ hdl/llconv_pkg.sv @@
package llconv_pkg;

    // Field widths of the linear power-bus converter.
    localparam int VAL_W    = 42;          // fixed-point value, 16 fraction bits
    localparam int VALX_W   = VAL_W + 1;   // value plus one carry bit
    localparam int RAW_W    = 16;          // linear bus word
    localparam int MODE_W   = 2;
    localparam int MANT_W   = 11;          // LINEAR11 mantissa
    localparam int EXP_W    = 5;           // LINEAR11 exponent
    localparam int EXP_N    = 32;          // exponents tried, -16 to 15
    localparam int EXP_BIAS = 16;          // exponent code = shift + bias (mod 32)
    localparam int L16_SHIFT = 6;          // value * 1024 / 65536

    // Mantissa limits for the LINEAR11 fit test.
    localparam int L11_POS_LIM = 1023;
    localparam int L11_NEG_LIM = 1024;

    // Stream word widths.
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENC_L11 = 2'd0,
        MODE_DEC_L11 = 2'd1,
        MODE_ENC_L16 = 2'd2,
        MODE_DEC_L16 = 2'd3
    } t_mode;

    // Magnitude bound for shift k: the rounded mantissa (mag + 2^(k-1)) >> k
    // stays within the limit exactly when mag is below this value.
    function automatic logic [VALX_W-1:0] l11_limit(input int unsigned k, input logic neg);
        logic [VALX_W-1:0] top;
        logic [VALX_W-1:0] half;
        top  = (neg ? VALX_W'(L11_NEG_LIM + 1) : VALX_W'(L11_POS_LIM + 1)) << k;
        half = (VALX_W'(1) << k) >> 1;
        return top - half;
    endfunction

endpackage

@@ hdl/linear11_linear16_converter_unit.sv @@
// Linear power-bus converter: LINEAR11 and LINEAR16 encode and decode.
// An accepted input word passes the input register, then the result register
// after the conversion logic. Throughput: one word per cycle; both stages
// advance whenever the result register is empty or being taken. Reset is
// synchronous and active low; it empties both stages, payload registers are
// not reset.
module linear11_linear16_converter_unit
    import llconv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [41:0] value_in, [57:42] raw_in, [63:58] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] raw_out, [57:16] value_out, [63:58] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] range_flag
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int PAD_W = M_TDATA_W - RAW_W - VAL_W;

    logic                    r_in_valid;
    t_mode                   r_mode;
    logic signed [VAL_W-1:0] r_value;
    logic [RAW_W-1:0]        r_raw;
    logic                    r_out_valid;
    logic [RAW_W-1:0]        r_out_raw;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_flag;

    logic                    adv_out;
    logic                    adv_in;
    logic [RAW_W-1:0]        l11_raw;
    logic                    l11_flag;
    logic [VAL_W-1:0]        mag;
    logic [VAL_W-L16_SHIFT-1:0] l16_t;
    logic [VAL_W-1:0]        mant_ext;
    logic [EXP_W-1:0]        dec_shift;
    logic [RAW_W-1:0]        n_out_raw;
    logic [VAL_W-1:0]        n_out_value;
    logic                    n_out_flag;

    // Stage handshakes: each stage takes a word when it is empty or the next one has room.
    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv_in        = !r_in_valid || adv_out;
    assign s_axis_tready = adv_in;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (adv_in && s_axis_tvalid) begin
            r_mode  <= t_mode'(s_axis_tuser[MODE_W-1:0]);
            r_value <= $signed(s_axis_tdata[VAL_W-1:0]);
            r_raw   <= s_axis_tdata[VAL_W +: RAW_W];
        end
    end

    llconv_l11_enc u_l11_enc (
        .i_value (r_value),
        .o_raw   (l11_raw),
        .o_flag  (l11_flag)
    );

    // LINEAR16 encode, both decodes and the result select for every mode.
    always_comb begin
        mag       = r_value[VAL_W-1] ? (~$unsigned(r_value) + VAL_W'(1)) : $unsigned(r_value);
        l16_t     = mag[VAL_W-1:L16_SHIFT];
        mant_ext  = {{(VAL_W - MANT_W){r_raw[MANT_W-1]}}, r_raw[MANT_W-1:0]};
        dec_shift = r_raw[RAW_W-1:MANT_W] + EXP_W'(EXP_BIAS);

        n_out_raw   = '0;
        n_out_value = '0;
        n_out_flag  = 1'b0;
        case (r_mode)
            MODE_ENC_L11: begin
                n_out_raw  = l11_raw;
                n_out_flag = l11_flag;
            end
            MODE_DEC_L11: begin
                n_out_value = mant_ext << dec_shift;
            end
            MODE_ENC_L16: begin
                if (r_value[VAL_W-1]) begin
                    n_out_flag = (l16_t != '0);
                end else if (l16_t[VAL_W-L16_SHIFT-1:RAW_W] != '0) begin
                    n_out_raw  = '1;
                    n_out_flag = 1'b1;
                end else begin
                    n_out_raw = l16_t[RAW_W-1:0];
                end
            end
            MODE_DEC_L16: begin
                n_out_value = {{(VAL_W - RAW_W - L16_SHIFT){1'b0}}, r_raw, {L16_SHIFT{1'b0}}};
            end
            default: begin
                n_out_raw = '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
        if (adv_out && r_in_valid) begin
            r_out_raw   <= n_out_raw;
            r_out_value <= n_out_value;
            r_out_flag  <= n_out_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_value, r_out_raw};
    assign m_axis_tuser  = r_out_flag;

endmodule

@@ hdl/llconv_l11_enc.sv @@
module llconv_l11_enc
    import llconv_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_value,
    output logic        [RAW_W-1:0] o_raw,
    output logic                    o_flag
);

    logic              neg;
    logic [VAL_W-1:0]  mag;
    logic [EXP_N-1:0]  fit;
    logic              found;
    logic [EXP_W-1:0]  sel;
    logic [VALX_W-1:0] half;
    logic [VALX_W-1:0] rounded;
    logic [MANT_W:0]   mant;
    logic [MANT_W-1:0] mant_bits;
    logic [EXP_W-1:0]  exp_code;

    // Magnitude of the input; the most negative value maps to 2^41.
    always_comb begin
        neg = i_value[VAL_W-1];
        mag = neg ? (~$unsigned(i_value) + VAL_W'(1)) : $unsigned(i_value);
    end

    // Fit test for every shift in parallel against constant bounds.
    always_comb begin
        for (int k = 0; k < EXP_N; k++) begin
            fit[k] = ({1'b0, mag} < l11_limit(k, neg));
        end
    end

    // Smallest shift that fits wins.
    always_comb begin
        found = |fit;
        sel   = '0;
        for (int k = EXP_N - 1; k >= 0; k--) begin
            if (fit[k]) begin
                sel = EXP_W'(k);
            end
        end
    end

    // Round half away from zero at the chosen shift and pack the word; zero or no fit gives an empty word.
    always_comb begin
        half      = (VALX_W'(1) << sel) >> 1;
        rounded   = ({1'b0, mag} + half) >> sel;
        mant      = rounded[MANT_W:0];
        mant_bits = neg ? (~mant[MANT_W-1:0] + MANT_W'(1)) : mant[MANT_W-1:0];
        exp_code  = sel + EXP_W'(EXP_BIAS);
        if (mag == '0) begin
            o_raw  = '0;
            o_flag = 1'b0;
        end else if (!found) begin
            o_raw  = '0;
            o_flag = 1'b1;
        end else begin
            o_raw  = {exp_code, mant_bits};
            o_flag = 1'b0;
        end
    end

endmodule

@@ hdl/llconv_checker.sv @@
module llconv_checker
    import llconv_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // An accepted word passes the input register into the result register when the output drains.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result word missing after pipeline latency");

    // A range flag comes only with an empty or saturated encoded word.
    a_flag_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[RAW_W-1:0] == '0 || m_axis_tdata[RAW_W-1:0] == '1)
            && m_axis_tdata[RAW_W +: VAL_W] == '0)
        else $error("range flag with unexpected payload");

    // A decoded value excludes any encoded word or flag.
    a_decode_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[RAW_W +: VAL_W] != '0 |->
            m_axis_tdata[RAW_W-1:0] == '0 && !m_axis_tuser[0])
        else $error("decoded value mixed with encode fields");

endmodule

bind linear11_linear16_converter_unit llconv_checker u_llconv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/llconv_result_checker.sv @@
`timescale 1ns / 100ps

module llconv_result_checker
    import llconv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // [41:0] value_in, [57:42] raw_in, [63:58] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // [15:0] raw_out, [57:16] value_out, [63:58] zero
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // [0] range_flag
    input  logic [M_TUSER_W-1:0] i_m_tuser,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_flagged
);

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [VAL_W-1:0] value;
        logic             flag;
    } t_conv_result;

    t_conv_result expected_q[$];
    t_conv_result want;
    t_conv_result seen;

    // Works out the result word for one input word, with exact integer math.
    function automatic t_conv_result compute_conversion(
        input t_mode            mode,
        input logic [VAL_W-1:0] value,
        input logic [RAW_W-1:0] word
    );
        t_conv_result     res;
        logic             neg;
        logic             fit;
        logic [VAL_W-1:0] neg_value;
        logic [63:0]      mag;
        logic [63:0]      mant;
        logic [63:0]      lim;
        logic [EXP_W-1:0] shift_code;
        res       = '0;
        neg       = value[VAL_W-1];
        neg_value = ~value + 1'b1;
        // The most negative value has a magnitude of 2^41, which still fits unsigned.
        mag       = neg ? 64'(neg_value) : 64'(value);
        lim       = neg ? 64'(L11_NEG_LIM) : 64'(L11_POS_LIM);
        case (mode)
            MODE_ENC_L11: begin
                if (mag != 64'd0) begin
                    fit = 1'b0;
                    // Try exponents from -16 upward; round half away from zero.
                    for (int k = 0; k < EXP_N; k++) begin
                        if (!fit) begin
                            mant = (k == 0) ? mag : ((mag + (64'd1 << (k - 1))) >> k);
                            if (mant <= lim) begin
                                fit = 1'b1;
                                if (neg) begin
                                    mant = ~mant + 64'd1;
                                end
                                res.raw = {EXP_W'(k + EXP_BIAS), mant[MANT_W-1:0]};
                            end
                        end
                    end
                    res.flag = !fit;
                end
            end
            MODE_ENC_L16: begin
                mant = mag >> L16_SHIFT;
                if (neg) begin
                    // Negative inputs clamp to zero; flagged only if they did not truncate away.
                    res.flag = (mant != 64'd0);
                end else if (mant > 64'({RAW_W{1'b1}})) begin
                    res.raw  = {RAW_W{1'b1}};
                    res.flag = 1'b1;
                end else begin
                    res.raw = mant[RAW_W-1:0];
                end
            end
            MODE_DEC_L11: begin
                mant       = 64'($signed(word[MANT_W-1:0]));
                shift_code = word[RAW_W-1:MANT_W] + EXP_W'(EXP_BIAS);
                res.value  = VAL_W'(mant << shift_code);
            end
            default: begin
                res.value = VAL_W'(64'(word) << L16_SHIFT);
            end
        endcase
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Results are taken before inputs: a word accepted now cannot leave this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_flagged    = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.raw   = i_m_tdata[RAW_W-1:0];
                seen.value = i_m_tdata[RAW_W +: VAL_W];
                seen.flag  = i_m_tuser[0];
                o_checked++;
                if (seen.flag) begin
                    o_flagged++;
                end
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, seen);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("raw_out", 64'(want.raw), 64'(seen.raw));
                    compare_field("value_out", 64'(want.value), 64'(seen.value));
                    compare_field("range_flag", 64'(want.flag), 64'(seen.flag));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(compute_conversion(t_mode'(i_s_tuser),
                                                        i_s_tdata[VAL_W-1:0],
                                                        i_s_tdata[VAL_W +: RAW_W]));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ verif/linear11_linear16_converter_unit_tb.sv @@
`timescale 1ns / 100ps

module linear11_linear16_converter_unit_tb;
    import llconv_pkg::*;

    localparam int N_RANDOM    = 1800;
    localparam int CALM_ITEMS  = 200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 40;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int flagged;

    // Stimulus shaping for the sender and the receiver.
    logic calm;
    logic hold_request;
    logic hold_done;
    int   gap_odds;
    int   stall_odds;
    int   words_by_mode[4];

    linear11_linear16_converter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    llconv_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    // Clock with a 20 ns period.
    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Hard stop in case the handshake hangs.
    initial begin
        #5_000_000;
        $display("Timeout waiting for the converter.");
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one word at a falling edge and holds it until it is accepted.
    task automatic send_word(input t_mode mode, input logic [VAL_W-1:0] value,
                             input logic [RAW_W-1:0] word);
        if (!calm && $urandom_range(0, 99) < gap_odds) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            s_axis_tuser  = S_TUSER_W'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid               = 1'b1;
        s_axis_tuser                = mode;
        s_axis_tdata                = '0;
        s_axis_tdata[VAL_W-1:0]     = value;
        s_axis_tdata[VAL_W +: RAW_W] = word;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        words_by_mode[int'(mode)]++;
        @(negedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold-off, none at the end.
    initial begin
        m_axis_tready = 1'b0;
        stall_odds    = 0;
        hold_done     = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            if (hold_request && !hold_done) begin
                m_axis_tready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(negedge i_clk);
                end
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 15;
                    default: stall_odds = 40;
                endcase
            end
            if (!calm && $urandom_range(0, 99) < stall_odds) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [63:0]      rnd;
        logic [63:0]      mag;
        logic [VAL_W-1:0] value;
        t_mode            mode;
        int               k;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        gap_odds      = 0;
        for (int m = 0; m < 4; m++) begin
            words_by_mode[m] = 0;
        end

        // Synchronous reset, then release.
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, ties, the no-fit case and the extremes of each mode.
        send_word(MODE_ENC_L11, '0, 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(1), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(-1), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(2045), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(2047), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(-2047), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(-2049), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_W'(1023 << 16), 16'($urandom));
        send_word(MODE_ENC_L11, VAL_MAX, 16'($urandom));
        send_word(MODE_ENC_L11, VAL_MIN, 16'($urandom));
        send_word(MODE_DEC_L11, VAL_W'({$urandom, $urandom}), 16'h0000);
        send_word(MODE_DEC_L11, VAL_W'({$urandom, $urandom}), 16'h7BFF);
        send_word(MODE_DEC_L11, VAL_W'({$urandom, $urandom}), 16'h83FF);
        send_word(MODE_DEC_L11, VAL_W'({$urandom, $urandom}), 16'h0400);
        send_word(MODE_DEC_L11, VAL_W'({$urandom, $urandom}), 16'hFFFF);
        send_word(MODE_ENC_L16, VAL_W'(63), 16'($urandom));
        send_word(MODE_ENC_L16, VAL_W'(-1), 16'($urandom));
        send_word(MODE_ENC_L16, VAL_W'(-64), 16'($urandom));
        send_word(MODE_ENC_L16, VAL_W'(42'h3F_FFFF), 16'($urandom));
        send_word(MODE_ENC_L16, VAL_W'(42'h40_0000), 16'($urandom));
        send_word(MODE_ENC_L16, VAL_MIN, 16'($urandom));
        send_word(MODE_DEC_L16, VAL_W'({$urandom, $urandom}), 16'hFFFF);
        send_word(MODE_DEC_L16, VAL_W'({$urandom, $urandom}), 16'h8000);

        // Random words, half of them near the rounding and clamping boundaries.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 15;
                    default: gap_odds = 40;
                endcase
            end
            if (i == HOLD_AT) begin
                hold_request = 1'b1;
            end
            if (i == N_RANDOM - CALM_ITEMS) begin
                calm = 1'b1;
            end
            rnd = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: mag = rnd;
                1: mag = rnd & ((64'd1 << $urandom_range(1, 41)) - 64'd1);
                2: begin
                    // Around the point where the rounded mantissa leaves its range.
                    k   = $urandom_range(1, 31);
                    mag = (64'($urandom_range(1019, 1024)) << k) - (64'd1 << (k - 1))
                          + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: begin
                    // Near zero or near the LINEAR16 clamp.
                    mag = (rnd[0] ? (64'h1_0000 << L16_SHIFT) - 64'd64 : 64'd0)
                          + 64'($urandom_range(0, 127));
                end
            endcase
            value = $urandom_range(0, 1) ? VAL_W'(~mag + 64'd1) : VAL_W'(mag);
            mode  = t_mode'($urandom_range(0, 3));
            send_word(mode, value, 16'($urandom));
        end
        s_axis_tvalid = 1'b0;

        // Drain, then keep watching for any stray word.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Words sent: %0d L11 enc, %0d L11 dec, %0d L16 enc, %0d L16 dec.",
                 words_by_mode[int'(MODE_ENC_L11)], words_by_mode[int'(MODE_DEC_L11)],
                 words_by_mode[int'(MODE_ENC_L16)], words_by_mode[int'(MODE_DEC_L16)]);
        $display("Checked %0d result words, %0d flagged, with one long output stall.",
                 checked, flagged);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
